// ----- src/rcq_pkg.sv -----
// shared types and constants for the rc channel command qualifier
`timescale 1ns / 1ps

package rcq_pkg;

  localparam int unsigned ValueWidth   = 16;
  localparam int unsigned TimeWidth    = 32;
  localparam int unsigned ChanWidth    = 8;
  localparam int unsigned MsWidth      = 16;
  localparam int unsigned CfgIdxWidth  = 2;

  localparam logic [ValueWidth-1:0] JumpLimit    = 16'd32;
  localparam logic [ChanWidth-1:0]  MaxChannel   = 8'd16;
  localparam logic [MsWidth-1:0]    HoldoffReset = 16'd2000;
  localparam logic [MsWidth-1:0]    PersistReset = 16'd2000;

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_CHANNEL = 2'd0,
    CFG_HOLDOFF = 2'd1,
    CFG_PERSIST = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [ChanWidth-1:0] channel;
    logic [MsWidth-1:0]   holdoff;
    logic [MsWidth-1:0]   persist;
  } cfg_t;

  typedef struct packed {
    logic [TimeWidth-1:0]  last_cmd_time;
    logic [ValueWidth-1:0] pending_value;
    logic [TimeWidth-1:0]  pending_start;
    logic [ValueWidth-1:0] last_cmd_value;
    logic                  first_seen;
  } state_t;

  typedef struct packed {
    logic                  enabled;
    logic                  update;
    state_t                next;
    logic                  accepted;
    logic                  run;
    logic [ValueWidth-1:0] value;
  } decision_t;

  function automatic logic [ValueWidth-1:0] abs_diff(input logic [ValueWidth-1:0] a,
                                                    input logic [ValueWidth-1:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

// ----- src/rc_channel_command_qualifier.sv -----
// top level: input register, qualifier state, result register
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+-------------------------------------------
//  sample   | in_valid_i / in_ready_o   | sample_value_i[15:0], now_ms_i[31:0]
//  result   | out_valid_o / out_ready_i | command_accepted_o, command_run_o,
//           |                           | command_value_o[15:0]
//  config   | cfg_valid_i / cfg_ready_o | cfg_index_i[1:0], cfg_data_i[15:0]
//
// one sample per cycle while the result register is not stalled; a sample passes
// through the input register, then the qualifier logic, into the result register
// the state registers update in the same edge that loads the result register
// a stalled result holds the input register; a new sample is still taken while
// the input register is empty or moves on
// reset clears the state to zero and the configuration to its defaults
`timescale 1ns / 1ps

module rc_channel_command_qualifier (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [rcq_pkg::ValueWidth-1:0]      sample_value_i,
  input  logic [rcq_pkg::TimeWidth-1:0]       now_ms_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                command_accepted_o,
  output logic                                command_run_o,
  output logic [rcq_pkg::ValueWidth-1:0]      command_value_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [rcq_pkg::CfgIdxWidth-1:0]     cfg_index_i,
  input  logic [rcq_pkg::MsWidth-1:0]         cfg_data_i
);

  rcq_pkg::cfg_t      cfg;
  rcq_pkg::decision_t dec;
  rcq_pkg::state_t    state_q, state_d;

  logic                              s1_valid_q, s1_valid_d;
  logic [rcq_pkg::ValueWidth-1:0]    s1_value_q;
  logic [rcq_pkg::TimeWidth-1:0]     s1_now_q;
  logic                              s1_advance;
  logic                              out_valid_q, out_valid_d;
  logic                              out_accepted_q, out_run_q;
  logic [rcq_pkg::ValueWidth-1:0]    out_value_q;

  assign cfg_ready_o = 1'b1;

  rcq_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  rcq_decide u_decide (
    .cfg_i          (cfg),
    .state_i        (state_q),
    .sample_value_i (s1_value_q),
    .now_ms_i       (s1_now_q),
    .dec_o          (dec)
  );

  // result register frees up when empty or being drained
  assign s1_advance = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_advance;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_ready_o) begin
      s1_valid_d = in_valid_i;
    end
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (s1_advance) begin
      out_valid_d = 1'b1;
    end
    state_d = state_q;
    if (s1_advance && dec.update) begin
      state_d = dec.next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      state_q     <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_value_q <= sample_value_i;
      s1_now_q   <= now_ms_i;
    end
    if (s1_advance) begin
      out_accepted_q <= dec.accepted;
      out_run_q      <= dec.run;
      out_value_q    <= dec.value;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign command_accepted_o = out_accepted_q;
  assign command_run_o      = out_run_q;
  assign command_value_o    = out_value_q;

  // a run flag only comes with an accepted command
  a_run_needs_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && command_run_o |-> command_accepted_o)
    else $error("command_run without command_accepted");

  // a shown command has already marked the first command as seen
  a_first_seen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && command_accepted_o |-> state_q.first_seen)
    else $error("accepted command without first_seen set");

  // the shown command matches the stored last command and pending value
  a_cmd_matches_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && command_accepted_o |->
      (command_value_o == state_q.last_cmd_value) &&
      (command_value_o == state_q.pending_value))
    else $error("accepted value does not match qualifier state");

  // a disabled channel leaves the state untouched
  a_disabled_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_advance && !dec.enabled |=> $stable(state_q))
    else $error("state changed while channel disabled");

endmodule

// ----- src/rcq_cfg_regs.sv -----
// configuration registers: channel select, hold-off and persistence times
`timescale 1ns / 1ps

module rcq_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  input  logic [rcq_pkg::CfgIdxWidth-1:0]  cfg_index_i,
  input  logic [rcq_pkg::MsWidth-1:0]      cfg_data_i,
  output rcq_pkg::cfg_t                    cfg_o
);

  rcq_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (rcq_pkg::cfg_idx_e'(cfg_index_i))
        rcq_pkg::CFG_CHANNEL: cfg_d.channel = cfg_data_i[rcq_pkg::ChanWidth-1:0];
        rcq_pkg::CFG_HOLDOFF: cfg_d.holdoff = cfg_data_i;
        rcq_pkg::CFG_PERSIST: cfg_d.persist = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.channel <= '0;
      cfg_q.holdoff <= rcq_pkg::HoldoffReset;
      cfg_q.persist <= rcq_pkg::PersistReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- src/rcq_decide.sv -----
// per-sample qualification: channel enable, hold-off, persistence restart, deadband, acceptance
`timescale 1ns / 1ps

module rcq_decide (
  input  rcq_pkg::cfg_t                        cfg_i,
  input  rcq_pkg::state_t                      state_i,
  input  logic [rcq_pkg::ValueWidth-1:0]       sample_value_i,
  input  logic [rcq_pkg::TimeWidth-1:0]        now_ms_i,
  output rcq_pkg::decision_t                   dec_o
);

  logic                             enabled;
  logic [rcq_pkg::TimeWidth-1:0]    since_cmd;
  logic [rcq_pkg::TimeWidth-1:0]    since_pending;
  logic                             in_holdoff;
  logic                             restart;
  logic                             not_persisted;
  logic                             in_deadband;

  assign enabled       = (cfg_i.channel != '0) && (cfg_i.channel <= rcq_pkg::MaxChannel);
  // wrapping elapsed times
  assign since_cmd     = now_ms_i - state_i.last_cmd_time;
  assign since_pending = now_ms_i - state_i.pending_start;
  assign in_holdoff    = since_cmd < {{(rcq_pkg::TimeWidth-rcq_pkg::MsWidth){1'b0}}, cfg_i.holdoff};
  assign restart       = (rcq_pkg::abs_diff(sample_value_i, state_i.pending_value)
                          > rcq_pkg::JumpLimit) && (cfg_i.persist != '0);
  assign not_persisted = since_pending
                         < {{(rcq_pkg::TimeWidth-rcq_pkg::MsWidth){1'b0}}, cfg_i.persist};
  assign in_deadband   = rcq_pkg::abs_diff(sample_value_i, state_i.last_cmd_value)
                         < rcq_pkg::JumpLimit;

  always_comb begin
    dec_o          = '0;
    dec_o.enabled  = enabled;
    dec_o.next     = state_i;
    priority if (!enabled || in_holdoff) begin
      dec_o.update = 1'b0;
    end else if (restart) begin
      dec_o.update             = 1'b1;
      dec_o.next.pending_value = sample_value_i;
      dec_o.next.pending_start = now_ms_i;
    end else if (not_persisted || in_deadband) begin
      dec_o.update = 1'b0;
    end else begin
      dec_o.update              = 1'b1;
      dec_o.next.pending_value  = sample_value_i;
      dec_o.next.last_cmd_value = sample_value_i;
      dec_o.next.last_cmd_time  = now_ms_i;
      dec_o.next.first_seen     = 1'b1;
      dec_o.accepted            = 1'b1;
      dec_o.run                 = state_i.first_seen;
      dec_o.value               = sample_value_i;
    end
  end

endmodule
